// ----- rtl/fpsa_pkg.sv -----
`default_nettype none

package fpsa_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int MAX_ROWS = 4096;
    localparam int ROW_W    = 12;
    localparam int ROWS_W   = 13;
    localparam int COLS_CFG_W = 11;
    localparam int MIN_DIM  = 3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS    = 2'd1;

    localparam logic [COLS_CFG_W-1:0] GRID_COLUMNS_RESET = 11'd18;
    localparam logic [ROWS_W-1:0]     GRID_ROWS_RESET    = 13'd18;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

endpackage

`default_nettype wire

// ----- rtl/fpsa_in_if.sv -----
`default_nettype none

interface fpsa_in_if #(
    parameter int SAMPLE_BITS = fpsa_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_start;

    modport source (output valid, sample, frame_start, input ready);
    modport sink   (input valid, sample, frame_start, output ready);
endinterface

`default_nettype wire

// ----- rtl/fpsa_out_if.sv -----
`default_nettype none

interface fpsa_out_if #(
    parameter int SAMPLE_BITS = fpsa_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_COLUMNS = fpsa_pkg::MAX_COLUMNS_DEF
);
    logic                                valid;
    logic                                ready;
    logic signed [SAMPLE_BITS-1:0]       average;
    logic [fpsa_pkg::ROW_W-1:0]          row;
    logic [$clog2(MAX_COLUMNS)-1:0]      column;
    logic                                grid_done;

    modport source (output valid, average, row, column, grid_done, input ready);
    modport sink   (input valid, average, row, column, grid_done, output ready);
endinterface

`default_nettype wire

// ----- rtl/fpsa_cfg_if.sv -----
`default_nettype none

interface fpsa_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [fpsa_pkg::CFG_INDEX_W-1:0] index;
    logic [fpsa_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/fpsa_line_store.sv -----
`default_nettype none

module fpsa_line_store #(
    parameter int DEPTH = fpsa_pkg::MAX_COLUMNS_DEF,
    parameter int WIDTH = fpsa_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] prev_raddr,
    input  wire logic [$clog2(DEPTH)-1:0] second_raddr,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic signed [WIDTH-1:0]  prev_wdata,
    input  wire logic signed [WIDTH-1:0]  second_wdata,
    output logic signed [WIDTH-1:0]       prev_rdata,
    output logic signed [WIDTH-1:0]       second_rdata
);

    logic signed [WIDTH-1:0] prev_mem   [DEPTH];
    logic signed [WIDTH-1:0] second_mem [DEPTH];
    logic signed [WIDTH-1:0] prev_rdata_reg;
    logic signed [WIDTH-1:0] second_rdata_reg;

    // read-before-write on a shared address; the caller forwards
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prev_mem[waddr]   <= prev_wdata;
            second_mem[waddr] <= second_wdata;
        end
        if (rd_en)
        begin
            prev_rdata_reg   <= prev_mem[prev_raddr];
            second_rdata_reg <= second_mem[second_raddr];
        end
    end

    assign prev_rdata   = prev_rdata_reg;
    assign second_rdata = second_rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/five_point_stencil_average.sv -----
`default_nettype none

// channel   modport  handshake       carries
// samples   sink     valid/ready     sample, frame_start
// results   source   valid/ready     average, row, column, grid_done
// cfg       sink     valid/ready     index, data (ready tied high)
//
// One request per cycle sustained while ready is high. A result passes through
// line-buffer read, five-point sum, reciprocal multiply into the queue.
// Line buffers are not cleared after reset; rows 0 and 1 produce no result.
// ready drops while queued results plus requests in flight reach four, e.g.
// under a stalled results channel.

module five_point_stencil_average #(
    parameter int MAX_COLUMNS = fpsa_pkg::MAX_COLUMNS_DEF,
    parameter int SAMPLE_BITS = fpsa_pkg::SAMPLE_BITS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    fpsa_in_if.sink    samples,
    fpsa_out_if.source results,
    fpsa_cfg_if.sink   cfg
);

    localparam int PW      = $clog2(MAX_COLUMNS);
    localparam int CW      = $clog2(MAX_COLUMNS + 1);
    localparam int EXT_W   = 14;
    localparam int SB      = SAMPLE_BITS;
    localparam int SUM_W   = SB + 3;
    localparam int SHIFT   = SUM_W + 3;
    localparam int RCP_W   = SB + 4;
    localparam int PROD_W  = SUM_W + RCP_W;
    localparam int ROW_W   = fpsa_pkg::ROW_W;
    localparam int ROWS_W  = fpsa_pkg::ROWS_W;
    localparam int FDEPTH  = fpsa_pkg::FIFO_DEPTH;
    localparam int FAW     = fpsa_pkg::FIFO_AW;
    localparam int FCW     = fpsa_pkg::FIFO_CW;

    localparam logic [RCP_W-1:0] RECIP  = RCP_W'(((64'd1 << SHIFT) + 64'd4) / 64'd5);
    localparam logic [SUM_W-1:0] OFFSET = SUM_W'((64'd5 << (SB - 1)) + 64'd2);
    localparam logic [SB-1:0]    HALF   = SB'(64'd1 << (SB - 1));

    // configuration
    logic [fpsa_pkg::COLS_CFG_W-1:0] grid_columns_reg;
    logic [ROWS_W-1:0]               grid_rows_reg;
    logic [CW-1:0]                   cols_eff;
    logic [ROWS_W-1:0]               rows_eff;
    logic [EXT_W-1:0]                cols_ext;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= fpsa_pkg::GRID_COLUMNS_RESET;
            grid_rows_reg    <= fpsa_pkg::GRID_ROWS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                fpsa_pkg::REG_GRID_COLUMNS:
                    grid_columns_reg <= cfg.data[fpsa_pkg::COLS_CFG_W-1:0];
                fpsa_pkg::REG_GRID_ROWS:
                    grid_rows_reg <= cfg.data[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cols_ext = EXT_W'(grid_columns_reg);
        if (cols_ext < EXT_W'(fpsa_pkg::MIN_DIM))
            cols_ext = EXT_W'(fpsa_pkg::MIN_DIM);
        else if (cols_ext > EXT_W'(MAX_COLUMNS))
            cols_ext = EXT_W'(MAX_COLUMNS);
        cols_eff = CW'(cols_ext);

        rows_eff = grid_rows_reg;
        if (rows_eff < ROWS_W'(fpsa_pkg::MIN_DIM))
            rows_eff = ROWS_W'(fpsa_pkg::MIN_DIM);
        else if (rows_eff > ROWS_W'(fpsa_pkg::MAX_ROWS))
            rows_eff = ROWS_W'(fpsa_pkg::MAX_ROWS);
    end

    // pipeline state
    logic [ROW_W-1:0] row_pos_reg, row_pos_next;
    logic [PW-1:0]    col_pos_reg, col_pos_next;

    logic                 s1_v_reg;
    logic [PW-1:0]        s1_c_reg;
    logic [ROW_W-1:0]     s1_r_reg;
    logic signed [SB-1:0] s1_sample_reg;
    logic                 s1_east_reg;
    logic                 s1_c0_reg;
    logic                 s1_produce_reg;
    logic                 s1_done_reg;
    logic                 s1_fwdp_reg;
    logic                 s1_fwds_reg;
    logic signed [SB-1:0] s1_fwdp_data_reg;
    logic signed [SB-1:0] s1_fwds_data_reg;

    logic signed [SB-1:0] win_west_reg;
    logic signed [SB-1:0] win_center_reg;
    logic signed [SB-1:0] prev0_reg;

    logic                 s2_v_reg;
    logic [SUM_W-1:0]     s2_m_reg;
    logic [ROW_W-1:0]     s2_row_reg;
    logic [PW-1:0]        s2_col_reg;
    logic                 s2_done_reg;

    logic [FCW-1:0]       fifo_count_reg, fifo_count_next;
    logic [FAW-1:0]       fifo_wr_ptr_reg;
    logic [FAW-1:0]       fifo_rd_ptr_reg;
    logic signed [SB-1:0] fifo_avg   [FDEPTH];
    logic [ROW_W-1:0]     fifo_row   [FDEPTH];
    logic [PW-1:0]        fifo_col   [FDEPTH];
    logic                 fifo_done  [FDEPTH];

    // stage 0: position and line-buffer read
    logic             accept;
    logic [FCW:0]     occupancy;
    logic [ROW_W-1:0] r0;
    logic [PW-1:0]    c0;
    logic [ROWS_W-1:0] r_n;
    logic [ROWS_W-1:0] r_inc;
    logic [PW-1:0]    cur_c;
    logic [ROW_W-1:0] cur_r;
    logic [CW-1:0]    c_plus1;
    logic [CW:0]      c_plus2;
    logic             has_east;
    logic             produce;
    logic             done;
    logic [PW-1:0]    prev_raddr;
    logic [PW-1:0]    second_raddr;

    assign occupancy = (FCW + 1)'(fifo_count_reg) + (FCW + 1)'(s1_v_reg)
                     + (FCW + 1)'(s2_v_reg);
    assign samples.ready = occupancy < (FCW + 1)'(FDEPTH);
    assign accept = samples.valid && samples.ready;

    always_comb
    begin
        r0 = samples.frame_start ? '0 : row_pos_reg;
        c0 = samples.frame_start ? '0 : col_pos_reg;
        cur_c = c0;
        r_n = ROWS_W'(r0);
        if (CW'(c0) >= cols_eff)
        begin
            cur_c = '0;
            r_n = ROWS_W'(r0) + ROWS_W'(1);
        end
        if (r_n >= rows_eff)
            r_n = '0;
        cur_r = r_n[ROW_W-1:0];

        c_plus1 = CW'(cur_c) + CW'(1);
        c_plus2 = (CW + 1)'(c_plus1) + (CW + 1)'(1);
        has_east = c_plus1 < cols_eff;
        produce = (cur_r >= ROW_W'(2)) && (cur_c != '0) && has_east;
        done = ((ROWS_W'(cur_r) + ROWS_W'(1)) == rows_eff)
            && (c_plus2 == (CW + 1)'(cols_eff));

        r_inc = ROWS_W'(cur_r) + ROWS_W'(1);
        if (has_east)
        begin
            col_pos_next = PW'(c_plus1);
            row_pos_next = cur_r;
        end
        else
        begin
            col_pos_next = '0;
            row_pos_next = (r_inc >= rows_eff) ? '0 : r_inc[ROW_W-1:0];
        end

        prev_raddr   = PW'(c_plus1);
        second_raddr = cur_c;
    end

    // stage 1: window, sum, write-back
    logic signed [SB-1:0] prev_q;
    logic signed [SB-1:0] second_q;
    logic signed [SB-1:0] east;
    logic signed [SB-1:0] north;
    logic signed [SB-1:0] center;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]     m_next;

    always_comb
    begin
        if (!s1_east_reg)
            east = '0;
        else if (s1_fwdp_reg)
            east = s1_fwdp_data_reg;
        else
            east = prev_q;
        north  = s1_fwds_reg ? s1_fwds_data_reg : second_q;
        center = s1_c0_reg ? prev0_reg : win_center_reg;
        sum = SUM_W'(center) + SUM_W'(north) + SUM_W'(east)
            + SUM_W'(s1_sample_reg) + SUM_W'(win_west_reg);
        // biased so the floor division by five works on an unsigned value
        m_next = $unsigned(sum) + OFFSET;
    end

    fpsa_line_store #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (SB)
    ) u_line_store (
        .clk          (clk),
        .rd_en        (accept),
        .prev_raddr   (prev_raddr),
        .second_raddr (second_raddr),
        .wr_en        (s1_v_reg),
        .waddr        (s1_c_reg),
        .prev_wdata   (s1_sample_reg),
        .second_wdata (center),
        .prev_rdata   (prev_q),
        .second_rdata (second_q)
    );

    // stage 2: reciprocal multiply
    logic [PROD_W-1:0] product;
    logic [SB-1:0]     avg_bits;

    assign product  = PROD_W'(s2_m_reg) * PROD_W'(RECIP);
    assign avg_bits = product[SHIFT +: SB] - HALF;

    // result queue
    logic pop;

    assign pop = (fifo_count_reg != '0) && results.ready;

    always_comb
    begin
        fifo_count_next = fifo_count_reg;
        if (s2_v_reg && !pop)
            fifo_count_next = fifo_count_reg + FCW'(1);
        else if (!s2_v_reg && pop)
            fifo_count_next = fifo_count_reg - FCW'(1);
    end

    assign results.valid     = fifo_count_reg != '0;
    assign results.average   = fifo_avg[fifo_rd_ptr_reg];
    assign results.row       = fifo_row[fifo_rd_ptr_reg];
    assign results.column    = fifo_col[fifo_rd_ptr_reg];
    assign results.grid_done = fifo_done[fifo_rd_ptr_reg];

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg     <= '0;
            col_pos_reg     <= '0;
            s1_v_reg        <= 1'b0;
            s2_v_reg        <= 1'b0;
            win_west_reg    <= '0;
            win_center_reg  <= '0;
            fifo_count_reg  <= '0;
            fifo_wr_ptr_reg <= '0;
            fifo_rd_ptr_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
            end
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg && s1_produce_reg;
            if (s1_v_reg)
            begin
                win_west_reg   <= center;
                win_center_reg <= east;
            end
            fifo_count_reg <= fifo_count_next;
            if (s2_v_reg)
                fifo_wr_ptr_reg <= fifo_wr_ptr_reg + FAW'(1);
            if (pop)
                fifo_rd_ptr_reg <= fifo_rd_ptr_reg + FAW'(1);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_c_reg       <= cur_c;
            s1_r_reg       <= cur_r;
            s1_sample_reg  <= samples.sample;
            s1_east_reg    <= has_east;
            s1_c0_reg      <= cur_c == '0;
            s1_produce_reg <= produce;
            s1_done_reg    <= done;
            // the request ahead writes its column during this read
            s1_fwdp_reg      <= s1_v_reg && (prev_raddr == s1_c_reg);
            s1_fwds_reg      <= s1_v_reg && (second_raddr == s1_c_reg);
            s1_fwdp_data_reg <= s1_sample_reg;
            s1_fwds_data_reg <= center;
        end
        if (s1_v_reg && s1_c_reg == '0)
            prev0_reg <= s1_sample_reg;
        if (s1_v_reg)
        begin
            s2_m_reg    <= m_next;
            s2_row_reg  <= s1_r_reg - ROW_W'(1);
            s2_col_reg  <= s1_c_reg;
            s2_done_reg <= s1_done_reg;
        end
        if (s2_v_reg)
        begin
            fifo_avg[fifo_wr_ptr_reg]  <= $signed(avg_bits);
            fifo_row[fifo_wr_ptr_reg]  <= s2_row_reg;
            fifo_col[fifo_wr_ptr_reg]  <= s2_col_reg;
            fifo_done[fifo_wr_ptr_reg] <= s2_done_reg;
        end
    end

endmodule

`default_nettype wire

// ----- verif/five_point_stencil_average_tb.sv -----
module five_point_stencil_average_tb;

    import fpsa_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned RANDOM_ITEMS  = 1650;
    localparam int unsigned GRID_ITEM_CAP = 200;

    localparam logic [23:0] SAMPLE_MAX = 24'h7FFFFF;
    localparam logic [23:0] SAMPLE_MIN = 24'h800000;
    localparam logic [23:0] MINUS_ONE  = 24'hFFFFFF;
    localparam logic [23:0] MINUS_3    = 24'hFFFFFD;

    typedef struct packed {
        logic [23:0] average;
        logic [11:0] row;
        logic [9:0]  column;
        logic        grid_done;
    } cell_mean_t;

    typedef struct packed {
        logic [23:0] sample;
        logic        frame_start;
        logic        typed;
        logic [23:0] average;
        logic [11:0] row;
        logic [9:0]  column;
        logic        grid_done;
    } stencil_vector_t;

    logic clk;
    logic rst_n;

    fpsa_in_if  sample_ch ();
    fpsa_out_if result_ch ();
    fpsa_cfg_if cfg_ch ();

    five_point_stencil_average dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    // 3x3 grids: all max, all min (wraps without frame_start), -3 south of center
    stencil_vector_t directed_vectors [27] = '{
        '{SAMPLE_MAX, 1'b1, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{SAMPLE_MAX, 1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{SAMPLE_MAX, 1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{SAMPLE_MAX, 1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{SAMPLE_MAX, 1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{SAMPLE_MAX, 1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{SAMPLE_MAX, 1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{SAMPLE_MAX, 1'b0, 1'b1, SAMPLE_MAX, 12'd1, 10'd1, 1'b1},
        '{SAMPLE_MAX, 1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{SAMPLE_MIN, 1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{SAMPLE_MIN, 1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{SAMPLE_MIN, 1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{SAMPLE_MIN, 1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{SAMPLE_MIN, 1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{SAMPLE_MIN, 1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{SAMPLE_MIN, 1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{SAMPLE_MIN, 1'b0, 1'b1, SAMPLE_MIN, 12'd1, 10'd1, 1'b1},
        '{SAMPLE_MIN, 1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{24'h0,      1'b1, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{24'h0,      1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{24'h0,      1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{24'h0,      1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{24'h0,      1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{24'h0,      1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{24'h0,      1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0},
        '{MINUS_3,    1'b0, 1'b1, MINUS_ONE,  12'd1, 10'd1, 1'b1},
        '{24'h0,      1'b0, 1'b0, 24'h0,      12'd0, 10'd0, 1'b0}
    };

    logic signed [23:0] above_line     [MAX_COLUMNS_DEF] = '{default: '0};
    logic signed [23:0] two_above_line [MAX_COLUMNS_DEF] = '{default: '0};
    logic signed [23:0] held_west   = '0;
    logic signed [23:0] held_center = '0;
    int unsigned        cur_row = 0;
    int unsigned        cur_col = 0;
    logic [COLS_CFG_W-1:0] grid_columns_reg = GRID_COLUMNS_RESET;
    logic [ROWS_W-1:0]     grid_rows_reg    = GRID_ROWS_RESET;

    cell_mean_t  expected_means [$];
    int unsigned failures     = 0;
    int unsigned samples_sent = 0;
    int unsigned cycle_count  = 0;
    bit          steady_flow  = 1'b0;

    function automatic int unsigned eff_columns();
        int unsigned c;
        c = grid_columns_reg;
        if (c < MIN_DIM)
            c = MIN_DIM;
        if (c > MAX_COLUMNS_DEF)
            c = MAX_COLUMNS_DEF;
        return c;
    endfunction

    function automatic int unsigned eff_rows();
        int unsigned r;
        r = grid_rows_reg;
        if (r < MIN_DIM)
            r = MIN_DIM;
        if (r > MAX_ROWS)
            r = MAX_ROWS;
        return r;
    endfunction

    function automatic bit stencil_step(input logic [23:0] raw, input logic frame_start,
                                        output cell_mean_t mean);
        int unsigned        cols;
        int unsigned        rows;
        int unsigned        r;
        int unsigned        c;
        logic signed [23:0] s;
        logic signed [23:0] center;
        logic signed [23:0] west;
        logic signed [23:0] east;
        logic signed [23:0] north;
        longint             twice_plus;
        longint             q;
        bit                 produced;
        cols = eff_columns();
        rows = eff_rows();
        s    = raw;
        mean = '0;
        if (frame_start)
        begin
            cur_row = 0;
            cur_col = 0;
        end
        r = cur_row;
        c = cur_col;
        if (c >= cols)
        begin
            c = 0;
            r++;
        end
        if (r >= rows)
            r = 0;
        center = (c == 0) ? above_line[0] : held_center;
        west   = held_west;
        east   = (c + 1 < cols) ? above_line[c + 1] : '0;
        north  = two_above_line[c];
        produced = (r >= 2 && c >= 1 && c + 1 < cols);
        if (produced)
        begin
            twice_plus = 2 * (longint'(center) + longint'(north) + longint'(east)
                            + longint'(s) + longint'(west)) + 5;
            q = twice_plus / 10;
            if (twice_plus % 10 != 0 && twice_plus < 0)
                q -= 1;
            mean.average   = q[23:0];
            mean.row       = 12'(r - 1);
            mean.column    = 10'(c);
            mean.grid_done = (r + 1 == rows && c + 2 == cols);
        end
        two_above_line[c] = center;
        above_line[c]     = s;
        held_west         = center;
        held_center       = east;
        c++;
        if (c >= cols)
        begin
            c = 0;
            r++;
            if (r >= rows)
                r = 0;
        end
        cur_row = r;
        cur_col = c;
        return produced;
    endfunction

    function automatic logic [23:0] random_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return 24'($urandom_range(10)) - 24'd5;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic push_sample(input logic [23:0] s, input logic fs, input bit typed,
                               input cell_mean_t typed_mean);
        cell_mean_t predicted;
        bit         produced;
        while (!steady_flow && $urandom_range(99) < 30)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.sample      <= s;
        sample_ch.frame_start <= fs;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        produced = stencil_step(s, fs, predicted);
        if (typed)
            expected_means.push_back(typed_mean);
        else if (produced)
            expected_means.push_back(predicted);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (index == REG_GRID_COLUMNS)
            grid_columns_reg = data[COLS_CFG_W-1:0];
        else if (index == REG_GRID_ROWS)
            grid_rows_reg = data[ROWS_W-1:0];
    endtask

    task automatic configure(input bit set_cols, input logic [CFG_DATA_W-1:0] cols_val,
                             input bit set_rows, input logic [CFG_DATA_W-1:0] rows_val);
        if (set_cols)
            write_reg(REG_GRID_COLUMNS, cols_val);
        if (set_rows)
            write_reg(REG_GRID_ROWS, rows_val);
        cfg_ch.valid <= 1'b0;
    endtask

    // wait out requests that produce nothing but may still be in the pipe
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_full_grid(input logic [CFG_DATA_W-1:0] cols_val,
                                 input logic [CFG_DATA_W-1:0] rows_val);
        int unsigned n;
        settle();
        configure(1'b1, cols_val, 1'b1, rows_val);
        n = eff_columns() * eff_rows();
        for (int unsigned i = 0; i < n; i++)
            push_sample(random_sample(), i == 0, 1'b0, '0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[five_point_stencil_average] ERROR");
        $finish;
    end

    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= steady_flow || ($urandom_range(99) >= 30);
        end
    end

    initial
    begin
        cell_mean_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (expected_means.size() == 0)
                begin
                    $display("%0t: expected no result, got average %h row %0d column %0d done %b",
                             $time, result_ch.average, result_ch.row, result_ch.column,
                             result_ch.grid_done);
                    failures++;
                end
                else
                begin
                    want = expected_means.pop_front();
                    if (result_ch.average !== want.average)
                    begin
                        $display("%0t: average expected %h got %h",
                                 $time, want.average, result_ch.average);
                        failures++;
                    end
                    if (result_ch.row !== want.row)
                    begin
                        $display("%0t: row expected %0d got %0d", $time, want.row, result_ch.row);
                        failures++;
                    end
                    if (result_ch.column !== want.column)
                    begin
                        $display("%0t: column expected %0d got %0d",
                                 $time, want.column, result_ch.column);
                        failures++;
                    end
                    if (result_ch.grid_done !== want.grid_done)
                    begin
                        $display("%0t: grid_done expected %b got %b",
                                 $time, want.grid_done, result_ch.grid_done);
                        failures++;
                    end
                end
            end
        end
    end

    initial
    begin
        cell_mean_t          typed_mean;
        int unsigned         random_start;
        int unsigned         old_cols;
        int unsigned         grid_items;
        int unsigned         grid_count;
        int unsigned         stop_at;
        logic [CFG_DATA_W-1:0] cols_val;
        logic [CFG_DATA_W-1:0] rows_val;
        bit                  set_cols;
        bit                  set_rows;
        bit                  need_start;
        logic                fs;

        rst_n                 <= 1'b0;
        sample_ch.valid       <= 1'b0;
        sample_ch.sample      <= '0;
        sample_ch.frame_start <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= REG_GRID_COLUMNS;
        cfg_ch.data           <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // below-range sizes clamp to a 3x3 grid
        configure(1'b1, 13'd1, 1'b1, 13'd0);
        foreach (directed_vectors[i])
        begin
            typed_mean = {directed_vectors[i].average, directed_vectors[i].row,
                          directed_vectors[i].column, directed_vectors[i].grid_done};
            push_sample(directed_vectors[i].sample, directed_vectors[i].frame_start,
                        directed_vectors[i].typed, typed_mean);
        end

        // tallest grid, then widest grid at full rate
        run_full_grid(13'd0, 13'h1FFF);
        settle();
        steady_flow = 1'b1;
        run_full_grid(13'h1FFF, 13'd2);
        settle();
        steady_flow = 1'b0;

        random_start = samples_sent;
        while (samples_sent - random_start < RANDOM_ITEMS)
        begin
            old_cols = eff_columns();
            if ($urandom_range(7) == 0)
                cols_val = $urandom_range(2);
            else
                cols_val = $urandom_range(12, 3);
            case ($urandom_range(15))
                0: rows_val = $urandom_range(2);
                1: rows_val = $urandom_range(8191, 4097);
                default: rows_val = $urandom_range(8, 3);
            endcase
            set_cols = $urandom_range(3) != 0;
            set_rows = $urandom_range(3) != 0;
            settle();
            configure(set_cols, cols_val, set_rows, rows_val);
            // a wider grid must restart so no unwritten line entry feeds a mean
            need_start = eff_columns() > old_cols;
            grid_items = eff_columns() * eff_rows();
            if (grid_items > GRID_ITEM_CAP)
                grid_items = GRID_ITEM_CAP;
            grid_count = $urandom_range(3, 1);
            for (int unsigned g = 0; g < grid_count; g++)
            begin
                stop_at = grid_items;
                if (g == grid_count - 1 && $urandom_range(1) == 0)
                    stop_at = $urandom_range(grid_items, 1);
                for (int unsigned i = 0; i < stop_at; i++)
                begin
                    if (i == 0)
                        fs = (g == 0 && need_start) || ($urandom_range(1) == 0);
                    else
                        fs = ($urandom_range(79) == 0);
                    push_sample(random_sample(), fs, 1'b0, '0);
                end
            end
        end

        settle();
        if (failures == 0)
            $display("[five_point_stencil_average] OK");
        else
            $display("[five_point_stencil_average] ERROR");
        $finish;
    end

endmodule
